// ----- rtl/bis_pkg.sv -----
`timescale 1ns / 1ps

package bis_pkg;

  localparam int COORD_W = 8;
  localparam int PIX_W = 8;
  localparam int DIM_W = 9;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_WIDTH = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS = 16;
  localparam int DIM_RESET = 256;
  localparam int DEF_BANK_DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT / 4;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  typedef struct packed {
    logic               command;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [PIX_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             error;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [DIM_W-1:0] src_dim;
    logic [DIM_W-1:0] dst_dim;
  } div_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH_X,
    ST_WAIT_X,
    ST_LAUNCH_Y,
    ST_WAIT_Y
  } step_state_t;

endpackage

// ----- rtl/bilinear_image_scaler.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// item      in         item_valid / item_ready  bis_pkg::in_item_t (command, col, row, value)
// result    out        result_valid/result_ready bis_pkg::out_item_t (pixel, error)
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One item is taken per cycle while the skid register is empty and no step is being
// recomputed. A compute item's result passes through the pipeline stages and then the
// output register; a load item writes the frame store at its transfer and yields nothing.
// The frame store is four banks split by x and y parity, so all four neighbors are
// read in the same cycle. A configuration write recomputes both steps, x then y, in a
// serial divider, during which items and further writes wait.
// Reset is synchronous and clears control state only; frame store contents are
// undefined until loaded. A result held at the output goes to a skid register, so
// item_ready never depends on result_ready in the same cycle.

module bilinear_image_scaler #(
  parameter int MAX_WIDTH = bis_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
  parameter int FRAC_BITS = bis_pkg::DEF_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  output logic                            item_ready,
  input  bis_pkg::in_item_t               item,
  output logic                            result_valid,
  input  logic                            result_ready,
  output bis_pkg::out_item_t              result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bis_pkg::DIM_W-1:0]       cfg_data
);

  localparam int DIM_W = bis_pkg::DIM_W;
  localparam int PIX_W = bis_pkg::PIX_W;
  localparam int COORD_W = bis_pkg::COORD_W;
  localparam int XHW = ($clog2(MAX_WIDTH) > 1) ? $clog2(MAX_WIDTH) - 1 : 1;
  localparam int YHW = ($clog2(MAX_HEIGHT) > 1) ? $clog2(MAX_HEIGHT) - 1 : 1;
  localparam int AW = XHW + YHW;
  localparam int BANK_DEPTH = 1 << AW;
  localparam int STEP_W = DIM_W + FRAC_BITS;
  localparam int PROD_W = COORD_W + STEP_W;
  localparam int HW = PIX_W + FRAC_BITS + 1;
  localparam int VW = HW + FRAC_BITS + 1;
  localparam int RST_W = (MAX_WIDTH < bis_pkg::DIM_RESET) ? MAX_WIDTH : bis_pkg::DIM_RESET;
  localparam int RST_H = (MAX_HEIGHT < bis_pkg::DIM_RESET) ? MAX_HEIGHT : bis_pkg::DIM_RESET;
  localparam logic [STEP_W-1:0] ONE_STEP = {{(DIM_W-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] ONE_FRAC = {1'b1, {FRAC_BITS{1'b0}}};

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    if (v == '0) begin
      return DIM_W'(1);
    end
    if (int'(v) > maxv) begin
      return DIM_W'(maxv);
    end
    return v;
  endfunction

  // Configuration and step computation.
  logic [DIM_W-1:0] src_width, src_height, dst_width, dst_height;
  logic [STEP_W-1:0] x_step, y_step, x_step_next, y_step_next;
  bis_pkg::step_state_t state, state_next;
  bis_pkg::div_req_t div_req;
  logic div_done;
  logic [STEP_W-1:0] div_q;
  logic cfg_fire;

  assign cfg_ready = state == bis_pkg::ST_IDLE;
  assign cfg_fire = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width <= DIM_W'(RST_W);
      src_height <= DIM_W'(RST_H);
      dst_width <= DIM_W'(RST_W);
      dst_height <= DIM_W'(RST_H);
    end else if (cfg_fire) begin
      case (cfg_index)
        bis_pkg::REG_SRC_WIDTH: src_width <= clamp_dim(cfg_data, MAX_WIDTH);
        bis_pkg::REG_SRC_HEIGHT: src_height <= clamp_dim(cfg_data, MAX_HEIGHT);
        bis_pkg::REG_DST_WIDTH: dst_width <= clamp_dim(cfg_data, MAX_WIDTH);
        bis_pkg::REG_DST_HEIGHT: dst_height <= clamp_dim(cfg_data, MAX_HEIGHT);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bis_pkg::ST_IDLE;
      x_step <= ONE_STEP;
      y_step <= ONE_STEP;
    end else begin
      state <= state_next;
      x_step <= x_step_next;
      y_step <= y_step_next;
    end
  end

  always_comb begin
    state_next = state;
    x_step_next = x_step;
    y_step_next = y_step;
    div_req = '0;
    case (state)
      bis_pkg::ST_IDLE: begin
        if (cfg_fire) begin
          state_next = bis_pkg::ST_LAUNCH_X;
        end
      end
      bis_pkg::ST_LAUNCH_X: begin
        div_req.start = 1'b1;
        div_req.src_dim = src_width;
        div_req.dst_dim = dst_width;
        state_next = bis_pkg::ST_WAIT_X;
      end
      bis_pkg::ST_WAIT_X: begin
        if (div_done) begin
          x_step_next = div_q;
          state_next = bis_pkg::ST_LAUNCH_Y;
        end
      end
      bis_pkg::ST_LAUNCH_Y: begin
        div_req.start = 1'b1;
        div_req.src_dim = src_height;
        div_req.dst_dim = dst_height;
        state_next = bis_pkg::ST_WAIT_Y;
      end
      bis_pkg::ST_WAIT_Y: begin
        if (div_done) begin
          y_step_next = div_q;
          state_next = bis_pkg::ST_IDLE;
        end
      end
      default: state_next = bis_pkg::ST_IDLE;
    endcase
  end

  bis_step_div #(.FRAC_BITS(FRAC_BITS)) u_step_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  // Pipeline control: every stage moves together unless the skid register is full.
  logic adv, item_fire;
  logic skid_valid;

  assign adv = !skid_valid;
  assign item_ready = adv && (state == bis_pkg::ST_IDLE);
  assign item_fire = item_valid && item_ready;

  // Loads write the bank chosen by the parity of x and y.
  logic load_ok;
  logic [1:0] load_bank;
  logic [AW-1:0] load_addr;

  assign load_ok = item_fire && (item.command == bis_pkg::CMD_LOAD) &&
                   ({1'b0, item.col} < src_width) && ({1'b0, item.row} < src_height);
  assign load_bank = {item.row[0], item.col[0]};
  assign load_addr = {YHW'(item.row >> 1), XHW'(item.col >> 1)};

  // Stage 1: scaled positions.
  logic v1, s1_err;
  logic [PROD_W-1:0] s1_px, s1_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= item_fire && (item.command == bis_pkg::CMD_COMPUTE);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px <= PROD_W'(item.col) * PROD_W'(x_step);
      s1_py <= PROD_W'(item.row) * PROD_W'(y_step);
      s1_err <= ({1'b0, item.col} >= dst_width) || ({1'b0, item.row} >= dst_height);
    end
  end

  logic [DIM_W-1:0] xl, yl;
  logic [FRAC_BITS-1:0] wx, wy;
  logic [DIM_W:0] x_sum, y_sum;
  logic [XHW-1:0] x_idx [2];
  logic [YHW-1:0] y_idx [2];

  assign xl = s1_px[FRAC_BITS +: DIM_W];
  assign yl = s1_py[FRAC_BITS +: DIM_W];
  assign wx = s1_px[FRAC_BITS-1:0];
  assign wy = s1_py[FRAC_BITS-1:0];

  // The even bank holds whichever of floor and ceiling is even, the odd bank the odd one.
  assign x_sum = {1'b0, xl} + (DIM_W + 1)'(xl[0]);
  assign y_sum = {1'b0, yl} + (DIM_W + 1)'(yl[0]);
  assign x_idx[0] = XHW'(x_sum >> 1);
  assign x_idx[1] = XHW'(xl >> 1);
  assign y_idx[0] = YHW'(y_sum >> 1);
  assign y_idx[1] = YHW'(yl >> 1);

  logic [PIX_W-1:0] rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bis_ram #(.WIDTH(PIX_W), .DEPTH(BANK_DEPTH)) u_bank (
      .clk   (clk),
      .we    (load_ok && (load_bank == 2'(b))),
      .waddr (load_addr),
      .wdata (item.value),
      .re    (adv),
      .raddr ({y_idx[b / 2], x_idx[b % 2]}),
      .rdata (rd[b])
    );
  end

  // Stage 2: neighbor selection and horizontal weighting.
  logic v2, s2_err, s2_xl0, s2_yl0, s2_xhp, s2_yhp;
  logic [FRAC_BITS-1:0] s2_wx, s2_wy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_err <= s1_err;
      s2_xl0 <= xl[0];
      s2_yl0 <= yl[0];
      s2_xhp <= xl[0] ^ (wx != '0);
      s2_yhp <= yl[0] ^ (wy != '0);
      s2_wx <= wx;
      s2_wy <= wy;
    end
  end

  logic [PIX_W-1:0] p00, p10, p01, p11;
  logic [FRAC_BITS:0] omx;

  // With a zero fraction the ceiling is the floor itself, so the same entry is used.
  assign p00 = rd[{s2_yl0, s2_xl0}];
  assign p10 = rd[{s2_yl0, s2_xhp}];
  assign p01 = rd[{s2_yhp, s2_xl0}];
  assign p11 = rd[{s2_yhp, s2_xhp}];
  assign omx = ONE_FRAC - {1'b0, s2_wx};

  // Stage 3: partial products.
  logic v3, s3_err;
  logic [FRAC_BITS-1:0] s3_wy;
  logic [HW-1:0] s3_t00, s3_t10, s3_t01, s3_t11;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_err <= s2_err;
      s3_wy <= s2_wy;
      s3_t00 <= HW'(p00) * HW'(omx);
      s3_t10 <= HW'(p10) * HW'(s2_wx);
      s3_t01 <= HW'(p01) * HW'(omx);
      s3_t11 <= HW'(p11) * HW'(s2_wx);
    end
  end

  // Stage 4: horizontal sums.
  logic v4, s4_err;
  logic [FRAC_BITS-1:0] s4_wy;
  logic [HW-1:0] s4_top, s4_bot;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_err <= s3_err;
      s4_wy <= s3_wy;
      s4_top <= s3_t00 + s3_t10;
      s4_bot <= s3_t01 + s3_t11;
    end
  end

  // Stage 5: vertical weighting.
  logic v5, s5_err;
  logic [VW-1:0] s5_m0, s5_m1;
  logic [FRAC_BITS:0] omy;

  assign omy = ONE_FRAC - {1'b0, s4_wy};

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_err <= s4_err;
      s5_m0 <= VW'(s4_top) * VW'(omy);
      s5_m1 <= VW'(s4_bot) * VW'(s4_wy);
    end
  end

  logic [VW-1:0] sum;
  bis_pkg::out_item_t res, skid;
  logic push;

  assign sum = s5_m0 + s5_m1;
  assign res.pixel = s5_err ? '0 : sum[2*FRAC_BITS +: PIX_W];
  assign res.error = s5_err;
  assign push = adv && v5;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      result <= skid_valid ? skid : res;
    end else if (push) begin
      skid <= res;
    end
  end

endmodule

// ----- rtl/bis_ram.sv -----
`timescale 1ns / 1ps

module bis_ram #(
  parameter int WIDTH = bis_pkg::PIX_W,
  parameter int DEPTH = bis_pkg::DEF_BANK_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write to the same entry in the same cycle return the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bis_step_div.sv -----
`timescale 1ns / 1ps

module bis_step_div #(
  parameter int FRAC_BITS = bis_pkg::DEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bis_pkg::div_req_t                   req,
  output logic                                done,
  output logic [bis_pkg::DIM_W+FRAC_BITS-1:0] quotient
);

  localparam int DIM_W = bis_pkg::DIM_W;
  localparam int STEP_W = DIM_W + FRAC_BITS;
  localparam int CNT_W = $clog2(STEP_W + 1);

  logic             active;
  logic [CNT_W-1:0] cnt;
  logic [STEP_W-1:0] shreg;
  logic [DIM_W-1:0] rem;
  logic [DIM_W-1:0] divisor;
  logic             zero_div;
  logic [DIM_W:0]   trial;
  logic             fits;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of shreg while quotient bits shift in at the bottom.
  assign trial = {rem, shreg[STEP_W-1]};
  assign fits = trial >= {1'b0, divisor};
  assign quotient = zero_div ? '0 : shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        cnt <= CNT_W'(STEP_W);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg <= {req.src_dim - DIM_W'(1), {FRAC_BITS{1'b0}}};
      rem <= '0;
      divisor <= req.dst_dim - DIM_W'(1);
      zero_div <= req.dst_dim <= DIM_W'(1);
    end else if (active) begin
      shreg <= {shreg[STEP_W-2:0], fits};
      rem <= fits ? DIM_W'(trial - {1'b0, divisor}) : trial[DIM_W-1:0];
    end
  end

endmodule
